// File: sv/iwc_pkg.sv
// Shared types and constants for the intensity window / colormap block.
// No dependencies; imported by every module of the block.
package iwc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // ln(1+t) unit: one quotient bit per stage, one series term per stage.
  // z <= 1/3 in Q0.32, so terms of order 21 and above are always zero.
  localparam int LN_DIV_STEPS = 32;
  localparam int LN_TERMS     = 10;
  localparam int LN_LAT       = LN_DIV_STEPS + LN_TERMS + 3;

  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;

  localparam logic [15:0] V_FULL = 16'd65280;  // 255.0 in Q8.8

  typedef enum logic [1:0] {
    SCALE_LINEAR  = 2'd0,
    SCALE_SQRT    = 2'd1,
    SCALE_SQUARED = 2'd2,
    SCALE_LN      = 2'd3
  } scale_mode_t;

  typedef enum logic [1:0] {
    COLOUR_GRAY   = 2'd0,
    COLOUR_JET    = 2'd1,
    COLOUR_WINTER = 2'd2,
    COLOUR_LINES  = 2'd3
  } colour_mode_t;

  typedef enum logic [2:0] {
    REG_CLIP_LOW   = 3'd0,
    REG_CLIP_HIGH  = 3'd1,
    REG_RANGE_RECP = 3'd2,
    REG_SCALE_MODE = 3'd3,
    REG_COLOUR     = 3'd4,
    REG_INVERT     = 3'd5
  } cfg_reg_t;

endpackage

// File: sv/intensity_window_colormap.sv
// Top level: window clip, normalize, intensity scaling and colormap.
// Depends on iwc_pkg, iwc_sqrt and iwc_ln1p.
//
// Usage:
//   Request channel: drive sample and pulse start. busy is always low, so a
//   request is taken at every edge where start is high; one per cycle.
//   Result channel: blue/green/red are valid for exactly one cycle while
//   done is high. The receiver cannot stall; results are never held.
//   The ln(1+t) path is the longest (32 divider stages, 10 series-term
//   stages); the other scale paths are delayed to line up with it.
//   Throughput: one pixel per clock, sustained.
//   Config: APB, 64-bit data, register i at byte address 8*i; pready is
//   always high. Write registers only while no request is in flight.
//   Reset (synchronous rst): pipeline valids clear, registers take
//   clip_low=0, clip_high=65535, range_reciprocal=65537, all modes 0.
module intensity_window_colormap
  import iwc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     sample,
  output logic                   done,
  output logic [7:0]             blue,
  output logic [7:0]             green,
  output logic [7:0]             red,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int FB = FRAC_BITS;
  localparam int K_SHORT = LN_LAT - 2;       // linear/squared align delay
  localparam int K_SQRT  = LN_LAT - FB - 1;  // sqrt align delay

  // ---------------- configuration registers ----------------
  logic signed [31:0] clip_low;
  logic signed [31:0] clip_high;
  logic [32:0]        range_reciprocal;
  scale_mode_t        scale_mode;
  colour_mode_t       colour_mode;
  logic               invert_enable;

  cfg_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = cfg_reg_t'(paddr[5:3]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_low         <= 32'sd0;
      clip_high        <= 32'sd65535;
      range_reciprocal <= 33'd65537;
      scale_mode       <= SCALE_LINEAR;
      colour_mode      <= COLOUR_GRAY;
      invert_enable    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CLIP_LOW:   clip_low         <= signed'(pwdata[31:0]);
        REG_CLIP_HIGH:  clip_high        <= signed'(pwdata[31:0]);
        REG_RANGE_RECP: range_reciprocal <= pwdata[32:0];
        REG_SCALE_MODE: scale_mode       <= scale_mode_t'(pwdata[1:0]);
        REG_COLOUR:     colour_mode      <= colour_mode_t'(pwdata[1:0]);
        REG_INVERT:     invert_enable    <= pwdata[0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CLIP_LOW:   prdata = {32'b0, clip_low};
      REG_CLIP_HIGH:  prdata = {32'b0, clip_high};
      REG_RANGE_RECP: prdata = {31'b0, range_reciprocal};
      REG_SCALE_MODE: prdata = {62'b0, scale_mode};
      REG_COLOUR:     prdata = {62'b0, colour_mode};
      REG_INVERT:     prdata = {63'b0, invert_enable};
      default:        prdata = '0;
    endcase
  end

  // ---------------- stage A: clip and offset ----------------
  logic               a_valid;
  logic [31:0]        a_d;
  logic               a_zero;
  logic               a_sat;
  logic signed [31:0] clipped;
  logic signed [32:0] diff;

  always_comb begin
    if (sample < clip_low)       clipped = clip_low;
    else if (sample > clip_high) clipped = clip_high;
    else                         clipped = sample;
    diff = 33'(clipped) - 33'(clip_low);
  end

  always_ff @(posedge clk) begin
    a_d    <= diff[31:0];
    // non-positive offset (also an inverted window) or zero reciprocal
    a_zero <= diff[32] | (diff == '0) | (range_reciprocal == '0);
    a_sat  <= range_reciprocal[32];
  end

  // ---------------- stage B: offset times reciprocal ----------------
  logic        b_valid;
  logic [63:0] b_prod;
  logic        b_zero;
  logic        b_sat;

  always_ff @(posedge clk) begin
    b_prod <= 64'(a_d) * 64'(range_reciprocal[31:0]);
    b_zero <= a_zero;
    b_sat  <= a_sat;
  end

  // ---------------- stage C: normalized t, Q1.FB ----------------
  logic              c_valid;
  logic [FB:0]       c_t;
  logic [31+FB:0]    tt;
  localparam logic [FB:0] T_ONE = {1'b1, {FB{1'b0}}};

  assign tt = b_prod[63:32-FB];

  always_ff @(posedge clk) begin
    if (b_zero)                        c_t <= '0;
    else if (b_sat)                    c_t <= T_ONE;
    else if (tt > (32+FB)'(T_ONE))     c_t <= T_ONE;
    else                               c_t <= (FB+1)'(tt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= start & ~busy;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // ---------------- linear and squared (stages D, E) ----------------
  logic [FB+8:0]   lin255;
  logic [15:0]     d_lin;
  logic [2*FB+1:0] d_sq;
  logic [2*FB+9:0] sq255;
  logic [15:0]     e_v;

  assign lin255 = {c_t, 8'b0} - (FB+9)'(c_t);
  assign sq255  = {d_sq, 8'b0} - (2*FB+10)'(d_sq);

  always_ff @(posedge clk) begin
    d_lin <= 16'(lin255 >> (FB - 8));
    d_sq  <= (2*FB+2)'(c_t) * (2*FB+2)'(c_t);
    if (scale_mode == SCALE_SQUARED) e_v <= 16'(sq255 >> (2*FB - 8));
    else                             e_v <= d_lin;
  end

  logic [15:0] sd [0:K_SHORT];
  assign sd[0] = e_v;
  for (genvar k = 1; k <= K_SHORT; k++) begin : g_sd
    always_ff @(posedge clk) begin
      sd[k] <= sd[k-1];
    end
  end

  // ---------------- square root path ----------------
  logic [15:0] sqrt_v;

  iwc_sqrt #(.FRAC_BITS(FB)) u_sqrt (
    .clk (clk),
    .t   (c_t),
    .v   (sqrt_v)
  );

  logic [15:0] qd [0:K_SQRT];
  assign qd[0] = sqrt_v;
  for (genvar k = 1; k <= K_SQRT; k++) begin : g_qd
    always_ff @(posedge clk) begin
      qd[k] <= qd[k-1];
    end
  end

  // ---------------- ln(1+t) path ----------------
  logic        ln_valid;
  logic [15:0] ln_v;

  iwc_ln1p #(.FRAC_BITS(FB)) u_ln (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .t         (c_t),
    .out_valid (ln_valid),
    .v         (ln_v)
  );

  // ---------------- stage F: select and invert ----------------
  logic        f_valid;
  logic [15:0] f_v;
  logic [15:0] v_sel;

  always_comb begin
    case (scale_mode)
      SCALE_SQRT: v_sel = qd[K_SQRT];
      SCALE_LN:   v_sel = ln_v;
      default:    v_sel = sd[K_SHORT];
    endcase
  end

  always_ff @(posedge clk) begin
    f_v <= invert_enable ? (V_FULL - v_sel) : v_sel;
  end

  // ---------------- colormap helpers ----------------
  function automatic logic [7:0] to_byte(input logic signed [19:0] x);
    if (x < 0)                       return 8'd0;
    else if (x[19:8] > 12'd255)      return 8'd255;
    else                             return x[15:8];
  endfunction

  // 8 = 1 mod 7: fold octal digits
  function automatic logic [2:0] mod7(input logic [7:0] a);
    logic [4:0] s;
    logic [3:0] s2;
    s  = 5'(a[7:6]) + 5'(a[5:3]) + 5'(a[2:0]);
    s2 = 4'(s[4:3]) + 4'(s[2:0]);
    if (s2 >= 4'd7) s2 = s2 - 4'd7;
    return s2[2:0];
  endfunction

  // palette index; 4'hF where the truncated value is negative
  function automatic logic [3:0] lines_idx(input logic [15:0] v,
                                           input logic [1:0] off);
    logic signed [17:0] x;
    x = signed'({2'b0, v}) - signed'({6'b0, off, 8'b0});
    if (x >= 0)             return {1'b0, mod7(x[15:8])};
    else if (x > -18'sd256) return 4'd0;
    else                    return 4'hF;
  endfunction

  localparam logic signed [19:0] Q1   = 20'sd256;
  localparam logic signed [19:0] Q28  = 20'sd7168;
  localparam logic signed [19:0] Q32  = 20'sd8192;
  localparam logic signed [19:0] Q96  = 20'sd24576;
  localparam logic signed [19:0] Q143 = 20'sd36608;
  localparam logic signed [19:0] Q160 = 20'sd40960;
  localparam logic signed [19:0] Q224 = 20'sd57344;
  localparam logic signed [19:0] Q255 = 20'sd65280;

  logic signed [19:0] vs;
  logic [7:0] jr, jg, jb;
  logic [7:0] lr, lg, lb;
  logic [3:0] ib, ig, ir;
  logic [7:0] b_n, g_n, r_n;

  assign vs = signed'({4'b0, f_v});
  assign ib = lines_idx(f_v, 2'd0);
  assign ig = lines_idx(f_v, 2'd1);
  assign ir = lines_idx(f_v, 2'd2);

  always_comb begin
    // jet; ramp starts of -1 clamp to 0 through to_byte
    if (vs < Q96)       jr = 8'd0;
    else if (vs < Q160) jr = to_byte(((vs - Q96) <<< 2) - Q1);
    else if (vs < Q224) jr = 8'd255;
    else                jr = to_byte(Q255 - ((vs - Q224) <<< 2));

    if (vs < Q32)       jg = 8'd0;
    else if (vs < Q96)  jg = to_byte(((vs - Q32) <<< 2) - Q1);
    else if (vs < Q160) jg = 8'd255;
    else if (vs < Q224) jg = to_byte(Q255 - ((vs - Q160) <<< 2));
    else                jg = 8'd0;

    if (vs < Q28)       jb = to_byte(Q143 + (vs <<< 2));
    else if (vs < Q96)  jb = 8'd255;
    else if (vs < Q160) jb = to_byte(Q255 - ((vs - Q96) <<< 2));
    else                jb = 8'd0;

    case (ib) inside
      4'd0:       lb = 8'd255;
      4'd3, 4'd4: lb = 8'd191;
      4'd6:       lb = 8'd63;
      default:    lb = 8'd0;
    endcase
    case (ig) inside
      4'd0:       lg = 8'd127;
      4'd2, 4'd4: lg = 8'd191;
      4'd5:       lg = 8'd63;
      default:    lg = 8'd0;
    endcase
    case (ir) inside
      4'd0:       lr = 8'd255;
      4'd2, 4'd3: lr = 8'd191;
      4'd4:       lr = 8'd63;
      default:    lr = 8'd0;
    endcase

    case (colour_mode)
      COLOUR_JET: begin
        b_n = jb; g_n = jg; r_n = jr;
      end
      COLOUR_WINTER: begin
        b_n = 8'((17'd130560 - 17'(f_v)) >> 9);
        g_n = f_v[15:8];
        r_n = 8'd0;
      end
      COLOUR_LINES: begin
        b_n = lb; g_n = lg; r_n = lr;
      end
      default: begin
        b_n = f_v[15:8]; g_n = f_v[15:8]; r_n = f_v[15:8];
      end
    endcase
  end

  // ---------------- stage G: result registers ----------------
  always_ff @(posedge clk) begin
    blue  <= b_n;
    green <= g_n;
    red   <= r_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      f_valid <= ln_valid;
      done    <= f_valid;
    end
  end

endmodule

// File: sv/iwc_sqrt.sv
// Pipelined square root of t << FRAC_BITS, scaled by 255 to Q8.8.
// Depends on iwc_pkg. One result bit per stage, then an output register.
module iwc_sqrt
  import iwc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   t,
  output logic [15:0]          v
);

  localparam int FB = FRAC_BITS;

  logic [2*FB-1:0] x    [0:FB];
  logic [FB+1:0]   rem  [0:FB];
  logic [FB-1:0]   root [0:FB];
  logic            full [0:FB];

  logic [2*FB-1:0] x_next    [0:FB-1];
  logic [FB+1:0]   rem_next  [0:FB-1];
  logic [FB-1:0]   root_next [0:FB-1];

  assign x[0]    = {t[FB-1:0], {FB{1'b0}}};
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign full[0] = t[FB];

  always_comb begin
    logic [FB+3:0] r4;
    logic [FB+3:0] trial;
    for (int i = 0; i < FB; i++) begin
      r4    = {rem[i], x[i][2*FB-1:2*FB-2]};
      trial = {2'b00, root[i], 2'b01};
      x_next[i] = {x[i][2*FB-3:0], 2'b00};
      if (r4 >= trial) begin
        rem_next[i]  = (FB+2)'(r4 - trial);
        root_next[i] = {root[i][FB-2:0], 1'b1};
      end else begin
        rem_next[i]  = (FB+2)'(r4);
        root_next[i] = {root[i][FB-2:0], 1'b0};
      end
    end
  end

  for (genvar i = 0; i < FB; i++) begin : g_stage
    always_ff @(posedge clk) begin
      x[i+1]    <= x_next[i];
      rem[i+1]  <= rem_next[i];
      root[i+1] <= root_next[i];
      full[i+1] <= full[i];
    end
  end

  logic [FB:0]   s;
  logic [FB+8:0] s255;

  assign s    = full[FB] ? {1'b1, {FB{1'b0}}} : {1'b0, root[FB]};
  assign s255 = {s, 8'b0} - (FB+9)'(s);

  always_ff @(posedge clk) begin
    v <= 16'(s255 >> (FB - 8));
  end

endmodule

// File: sv/iwc_ln1p.sv
// Pipelined ln(1+t) via 2*atanh(t/(2+t)), scaled by 255 to Q8.8.
// Depends on iwc_pkg. One item per cycle.
module iwc_ln1p
  import iwc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [FRAC_BITS:0] t,
  output logic               out_valid,
  output logic [15:0]        v
);

  localparam int FB = FRAC_BITS;
  localparam int DS = LN_DIV_STEPS;
  localparam int NT = LN_TERMS;

  // restoring divider: z = (t << 32) / (2^(FB+1) + t)
  logic [FB+1:0] dr [0:DS];
  logic [FB+1:0] dd [0:DS];
  logic [31:0]   dq [0:DS];
  logic          dv [0:DS];

  logic [FB+1:0] dr_next [0:DS-1];
  logic [31:0]   dq_next [0:DS-1];

  assign dr[0] = (FB+2)'(t);
  assign dd[0] = {1'b1, {(FB+1){1'b0}}} + (FB+2)'(t);
  assign dq[0] = '0;
  assign dv[0] = in_valid;

  always_comb begin
    logic [FB+2:0] r2;
    for (int i = 0; i < DS; i++) begin
      r2 = {dr[i], 1'b0};
      if (r2 >= {1'b0, dd[i]}) begin
        dr_next[i] = (FB+2)'(r2 - {1'b0, dd[i]});
        dq_next[i] = {dq[i][30:0], 1'b1};
      end else begin
        dr_next[i] = (FB+2)'(r2);
        dq_next[i] = {dq[i][30:0], 1'b0};
      end
    end
  end

  for (genvar i = 0; i < DS; i++) begin : g_div
    always_ff @(posedge clk) begin
      dr[i+1] <= dr_next[i];
      dd[i+1] <= dd[i];
      dq[i+1] <= dq_next[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else begin
        dv[i+1] <= dv[i];
      end
    end
  end

  // series: sum of floor(p_n / n), p_(n+2) = p_n * z^2 >> 32
  logic [31:0] sp   [0:NT];
  logic [31:0] sz2  [0:NT];
  logic [31:0] ssum [0:NT];
  logic [31:0] sq   [0:NT];
  logic        sv   [0:NT];

  logic [31:0] p_next [0:NT-1];
  logic [31:0] q_next [0:NT-1];

  logic [63:0] zz;
  assign zz = 64'(dq[DS]) * 64'(dq[DS]);

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int N = 2 * j + 1;
    localparam int L = $clog2(N);
    localparam logic [32:0] M = 33'(((65'd1 << (32 + L)) / 65'(N)) + 65'd1);
    logic [63:0] pz;
    logic [64:0] pm;
    assign pz        = 64'(sp[j]) * 64'(sz2[j]);
    assign pm        = 65'(sp[j]) * 65'(M);
    assign p_next[j] = pz[63:32];
    assign q_next[j] = 32'(pm >> (32 + L));
  end

  always_ff @(posedge clk) begin
    sp[0]   <= dq[DS];
    sz2[0]  <= zz[63:32];
    ssum[0] <= '0;
    sq[0]   <= '0;
    for (int j = 0; j < NT; j++) begin
      sp[j+1]   <= p_next[j];
      sz2[j+1]  <= sz2[j];
      sq[j+1]   <= q_next[j];
      ssum[j+1] <= ssum[j] + sq[j];
    end
  end

  logic [31:0] fsum;
  logic        fvalid;

  always_ff @(posedge clk) begin
    fsum <= ssum[NT] + sq[NT];
    v    <= 16'((41'(fsum) * 41'd510) >> 24);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0]     <= 1'b0;
      for (int j = 0; j < NT; j++) sv[j+1] <= 1'b0;
      fvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sv[0]     <= dv[DS];
      for (int j = 0; j < NT; j++) sv[j+1] <= sv[j];
      fvalid    <= sv[NT];
      out_valid <= fvalid;
    end
  end

endmodule
